// ----- design/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console character writer package
// Geometry constants, control character codes, and the command and status
// structures shared between the controller and the datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int unsigned ROWS = 32;
  localparam int unsigned COLS = 128;

  localparam int unsigned ROW_W   = 5;
  localparam int unsigned COL_W   = 8;
  localparam int unsigned RROW_W  = 5;
  localparam int unsigned RCOL_W  = 7;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COLOR_W = 32;

  localparam int unsigned ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned COL_AW  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned CUR_CW  = COL_AW + 1;
  localparam int unsigned ADDR_W  = ROW_AW + COL_AW;
  localparam int unsigned MEM_DEPTH = ROWS * (2 ** COL_AW);

  localparam logic [ROW_AW-1:0]  ROW_LAST = ROW_AW'(ROWS - 1);
  localparam logic [COL_AW-1:0]  COL_LAST = COL_AW'(COLS - 1);
  localparam logic [CUR_CW-1:0]  COL_FULL = CUR_CW'(COLS);

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [COLOR_W-1:0] BLANK_RESET = 32'h0000_0000;

  typedef enum logic [2:0] {
    KIND_READ,
    KIND_NEWLINE,
    KIND_RETURN,
    KIND_BACKSPACE,
    KIND_PRINT
  } kind_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_RDATA,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic capture;
    logic rd_issue;
    logic step_line;
    logic cr;
    logic bs;
    logic put;
    logic sweep_step;
    logic init;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  col_full;
    logic  col_zero;
    logic  row_last;
    logic  sweep_col_last;
    logic  sweep_row_last;
    logic  out_free;
  } sts_t;

endpackage

// ----- design/text_console_char_writer_core.sv -----
// ----------------------------------------------------------------------------
// Text console character writer
// Carriage return, backspace and ordinary bytes run in ST_EXEC; a read
// also visits ST_RDATA; a wrap without a scroll runs ST_EXEC twice.
// A scroll adds a pass that clears the new bottom row, one cell per cycle
// through the single store write port.
// After reset a clearing pass fills the store with spaces; in_stall_o
// stays high until it ends.
// ----------------------------------------------------------------------------
module text_console_char_writer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tccw_pkg::COLOR_W-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [tccw_pkg::CHAR_W-1:0]       char_code_i,
  input  logic [tccw_pkg::COLOR_W-1:0]      char_color_i,
  input  logic [tccw_pkg::RROW_W-1:0]       read_row_i,
  input  logic [tccw_pkg::RCOL_W-1:0]       read_col_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tccw_pkg::ROW_W-1:0]        cursor_row_o,
  output logic [tccw_pkg::COL_W-1:0]        cursor_col_o,
  output logic                              scrolled_o,
  output logic [tccw_pkg::CHAR_W-1:0]       cell_char_o,
  output logic [tccw_pkg::COLOR_W-1:0]      cell_color_o
);

  tccw_pkg::cmd_t cmd;
  tccw_pkg::sts_t sts;

  tccw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (cmd)
  );

  tccw_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd_i),
    .char_code_i  (char_code_i),
    .char_color_i (char_color_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .scrolled_o   (scrolled_o),
    .cell_char_o  (cell_char_o),
    .cell_color_o (cell_color_o),
    .ctl_i        (cmd),
    .sts_o        (sts)
  );

endmodule

// ----- design/tccw_dpath.sv -----
// ----------------------------------------------------------------------------
// Text console character writer datapath
// Holds the request, the cursor, the ring offset, the clearing sweep
// pointers, the cell store and the result register.
// ----------------------------------------------------------------------------
module tccw_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tccw_pkg::COLOR_W-1:0]      cfg_wdata_i,
  input  logic                              cmd_i,
  input  logic [tccw_pkg::CHAR_W-1:0]       char_code_i,
  input  logic [tccw_pkg::COLOR_W-1:0]      char_color_i,
  input  logic [tccw_pkg::RROW_W-1:0]       read_row_i,
  input  logic [tccw_pkg::RCOL_W-1:0]       read_col_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [tccw_pkg::ROW_W-1:0]        cursor_row_o,
  output logic [tccw_pkg::COL_W-1:0]        cursor_col_o,
  output logic                              scrolled_o,
  output logic [tccw_pkg::CHAR_W-1:0]       cell_char_o,
  output logic [tccw_pkg::COLOR_W-1:0]      cell_color_o,
  input  tccw_pkg::cmd_t                    ctl_i,
  output tccw_pkg::sts_t                    sts_o
);

  function automatic logic [tccw_pkg::ROW_AW-1:0] row_phys(
    input logic [tccw_pkg::ROW_AW-1:0] top,
    input logic [tccw_pkg::ROW_AW-1:0] logical
  );
    logic [tccw_pkg::ROW_AW:0] sum;
    sum = {1'b0, top} + {1'b0, logical};
    if (sum >= (tccw_pkg::ROW_AW + 1)'(tccw_pkg::ROWS)) begin
      sum = sum - (tccw_pkg::ROW_AW + 1)'(tccw_pkg::ROWS);
    end
    return sum[tccw_pkg::ROW_AW-1:0];
  endfunction

  logic [tccw_pkg::COLOR_W-1:0] blank_q;

  logic                          cmd_q;
  logic [tccw_pkg::CHAR_W-1:0]   code_q;
  logic [tccw_pkg::COLOR_W-1:0]  color_q;
  logic [tccw_pkg::RROW_W-1:0]   rrow_q;
  logic [tccw_pkg::RCOL_W-1:0]   rcol_q;

  logic [tccw_pkg::ROW_AW-1:0]   row_q, row_d;
  logic [tccw_pkg::CUR_CW-1:0]   col_q, col_d;
  logic [tccw_pkg::ROW_AW-1:0]   top_q, top_d;
  logic                          scr_q, scr_d;
  logic [tccw_pkg::ROW_AW-1:0]   swr_q, swr_d;
  logic [tccw_pkg::COL_AW-1:0]   swc_q, swc_d;

  logic                          we;
  logic [tccw_pkg::ADDR_W-1:0]   waddr;
  logic [tccw_pkg::CHAR_W-1:0]   wchar;
  logic [tccw_pkg::COLOR_W-1:0]  wcolor;
  logic [tccw_pkg::ADDR_W-1:0]   raddr;
  logic                          rd_ok;

  logic [tccw_pkg::CHAR_W-1:0]   char_mem  [tccw_pkg::MEM_DEPTH];
  logic [tccw_pkg::COLOR_W-1:0]  color_mem [tccw_pkg::MEM_DEPTH];
  logic [tccw_pkg::CHAR_W-1:0]   rchar_q;
  logic [tccw_pkg::COLOR_W-1:0]  rcolor_q;

  logic                          out_valid_q;
  logic [tccw_pkg::ROW_W-1:0]    out_row_q;
  logic [tccw_pkg::COL_W-1:0]    out_col_q;
  logic                          out_scr_q;
  logic [tccw_pkg::CHAR_W-1:0]   out_char_q;
  logic [tccw_pkg::COLOR_W-1:0]  out_color_q;

  logic [tccw_pkg::ROW_AW-1:0]   cur_phys;
  logic [tccw_pkg::CUR_CW-1:0]   bs_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= tccw_pkg::BLANK_RESET;
    end else if (cfg_we_i) begin
      blank_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q   <= cmd_i;
      code_q  <= char_code_i;
      color_q <= char_color_i;
      rrow_q  <= read_row_i;
      rcol_q  <= read_col_i;
    end
  end

  always_comb begin
    if (cmd_q) begin
      sts_o.kind = tccw_pkg::KIND_READ;
    end else if (code_q == tccw_pkg::CH_NEWLINE) begin
      sts_o.kind = tccw_pkg::KIND_NEWLINE;
    end else if (code_q == tccw_pkg::CH_RETURN) begin
      sts_o.kind = tccw_pkg::KIND_RETURN;
    end else if (code_q == tccw_pkg::CH_BACKSPACE) begin
      sts_o.kind = tccw_pkg::KIND_BACKSPACE;
    end else begin
      sts_o.kind = tccw_pkg::KIND_PRINT;
    end
    sts_o.col_full       = (col_q >= tccw_pkg::COL_FULL);
    sts_o.col_zero       = (col_q == '0);
    sts_o.row_last       = (row_q == tccw_pkg::ROW_LAST);
    sts_o.sweep_col_last = (swc_q == tccw_pkg::COL_LAST);
    sts_o.sweep_row_last = (swr_q == tccw_pkg::ROW_LAST);
    sts_o.out_free       = !out_valid_q || !out_stall_i;
  end

  assign cur_phys = row_phys(top_q, row_q);
  assign bs_col   = col_q - 1'b1;
  assign rd_ok    = (32'(rrow_q) < tccw_pkg::ROWS) && (32'(rcol_q) < tccw_pkg::COLS);
  assign raddr    = {row_phys(top_q, tccw_pkg::ROW_AW'(rrow_q)), tccw_pkg::COL_AW'(rcol_q)};

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    top_d  = top_q;
    scr_d  = scr_q;
    swr_d  = swr_q;
    swc_d  = swc_q;
    we     = 1'b0;
    waddr  = {cur_phys, col_q[tccw_pkg::COL_AW-1:0]};
    wchar  = tccw_pkg::CH_SPACE;
    wcolor = blank_q;
    if (ctl_i.capture) begin
      scr_d = 1'b0;
    end
    if (ctl_i.step_line) begin
      col_d = '0;
      if (sts_o.row_last) begin
        top_d = (top_q == tccw_pkg::ROW_LAST) ? '0 : top_q + 1'b1;
        scr_d = 1'b1;
        swr_d = top_q;
        swc_d = '0;
      end else begin
        row_d = row_q + 1'b1;
      end
    end
    if (ctl_i.cr) begin
      col_d = '0;
    end
    if (ctl_i.bs) begin
      col_d  = bs_col;
      we     = 1'b1;
      waddr  = {cur_phys, bs_col[tccw_pkg::COL_AW-1:0]};
    end
    if (ctl_i.put) begin
      col_d  = col_q + 1'b1;
      we     = 1'b1;
      wchar  = code_q;
      wcolor = color_q;
    end
    if (ctl_i.sweep_step) begin
      we     = 1'b1;
      waddr  = {swr_q, swc_q};
      wcolor = ctl_i.init ? tccw_pkg::BLANK_RESET : blank_q;
      if (sts_o.sweep_col_last) begin
        swc_d = '0;
        if (ctl_i.init) begin
          swr_d = sts_o.sweep_row_last ? '0 : swr_q + 1'b1;
        end
      end else begin
        swc_d = swc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      top_q <= '0;
      scr_q <= 1'b0;
      swr_q <= '0;
      swc_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      top_q <= top_d;
      scr_q <= scr_d;
      swr_q <= swr_d;
      swc_q <= swc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      char_mem[waddr]  <= wchar;
      color_mem[waddr] <= wcolor;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_issue) begin
      rchar_q  <= char_mem[raddr];
      rcolor_q <= color_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      out_row_q <= tccw_pkg::ROW_W'(row_d);
      out_col_q <= tccw_pkg::COL_W'(col_d);
      out_scr_q <= scr_d;
      if ((sts_o.kind == tccw_pkg::KIND_READ) && rd_ok) begin
        out_char_q  <= rchar_q;
        out_color_q <= rcolor_q;
      end else begin
        out_char_q  <= '0;
        out_color_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign scrolled_o   = out_scr_q;
  assign cell_char_o  = out_char_q;
  assign cell_color_o = out_color_q;

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= tccw_pkg::COL_FULL)
    else $error("Cursor column is beyond the full-row mark.");

  a_scroll_sweep_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.step_line && sts_o.row_last) |=> (swr_q == $past(top_q)) && (swc_q == '0))
    else $error("Scroll did not aim the sweep at the old top row.");

  a_scroll_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.step_line && sts_o.row_last) |=> scr_q && (row_q == tccw_pkg::ROW_LAST))
    else $error("Scroll left the cursor off the bottom row.");

endmodule

// ----- design/tccw_ctrl.sv -----
// ----------------------------------------------------------------------------
// Text console character writer controller
// Sequences the reset clearing pass, request execution, row clearing on a
// scroll, cell reads and the hand-over of each result.
// ----------------------------------------------------------------------------
module tccw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tccw_pkg::sts_t   sts_i,
  output tccw_pkg::cmd_t   ctl_o
);

  tccw_pkg::state_e state_q, state_d;
  tccw_pkg::state_e fin_state;

  assign fin_state = sts_i.out_free ? tccw_pkg::ST_IDLE : tccw_pkg::ST_RESULT;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tccw_pkg::ST_INIT: begin
        if (sts_i.sweep_col_last && sts_i.sweep_row_last) begin
          state_d = tccw_pkg::ST_IDLE;
        end
      end
      tccw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = tccw_pkg::ST_EXEC;
        end
      end
      tccw_pkg::ST_EXEC: begin
        case (sts_i.kind)
          tccw_pkg::KIND_READ: begin
            state_d = tccw_pkg::ST_RDATA;
          end
          tccw_pkg::KIND_NEWLINE: begin
            state_d = sts_i.row_last ? tccw_pkg::ST_SWEEP : fin_state;
          end
          tccw_pkg::KIND_PRINT: begin
            if (sts_i.col_full) begin
              state_d = sts_i.row_last ? tccw_pkg::ST_SWEEP : tccw_pkg::ST_EXEC;
            end else begin
              state_d = fin_state;
            end
          end
          default: begin
            state_d = fin_state;
          end
        endcase
      end
      tccw_pkg::ST_SWEEP: begin
        if (sts_i.sweep_col_last) begin
          state_d = (sts_i.kind == tccw_pkg::KIND_PRINT) ? tccw_pkg::ST_EXEC : fin_state;
        end
      end
      tccw_pkg::ST_RDATA, tccw_pkg::ST_RESULT: begin
        if (sts_i.out_free) begin
          state_d = tccw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tccw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      tccw_pkg::ST_INIT: begin
        ctl_o.sweep_step = 1'b1;
        ctl_o.init       = 1'b1;
      end
      tccw_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        ctl_o.capture = in_valid_i;
      end
      tccw_pkg::ST_EXEC: begin
        case (sts_i.kind)
          tccw_pkg::KIND_READ: begin
            ctl_o.rd_issue = 1'b1;
          end
          tccw_pkg::KIND_NEWLINE: begin
            ctl_o.step_line = 1'b1;
            ctl_o.load_out  = !sts_i.row_last && sts_i.out_free;
          end
          tccw_pkg::KIND_RETURN: begin
            ctl_o.cr       = 1'b1;
            ctl_o.load_out = sts_i.out_free;
          end
          tccw_pkg::KIND_BACKSPACE: begin
            ctl_o.bs       = !sts_i.col_zero;
            ctl_o.load_out = sts_i.out_free;
          end
          tccw_pkg::KIND_PRINT: begin
            if (sts_i.col_full) begin
              ctl_o.step_line = 1'b1;
            end else begin
              ctl_o.put      = 1'b1;
              ctl_o.load_out = sts_i.out_free;
            end
          end
          default: begin
            ctl_o.load_out = sts_i.out_free;
          end
        endcase
      end
      tccw_pkg::ST_SWEEP: begin
        ctl_o.sweep_step = 1'b1;
        ctl_o.load_out   = sts_i.sweep_col_last && (sts_i.kind != tccw_pkg::KIND_PRINT) &&
                           sts_i.out_free;
      end
      tccw_pkg::ST_RDATA, tccw_pkg::ST_RESULT: begin
        ctl_o.load_out = sts_i.out_free;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tccw_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load_out |-> sts_i.out_free)
    else $error("Result loaded over one not yet taken.");

  a_put_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.put |-> !sts_i.col_full)
    else $error("Character stored on a full row.");

  a_scroll_sweep_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.sweep_step && !ctl_o.init) |->
      (sts_i.kind == tccw_pkg::KIND_NEWLINE) || (sts_i.kind == tccw_pkg::KIND_PRINT))
    else $error("Row clearing started by a request that cannot scroll.");

endmodule
